### hw/rtl/fmd_pkg.sv
package fmd_pkg;

	localparam logic [3:0] KIND_ADD      = 4'd0;
	localparam logic [3:0] KIND_CONTROL  = 4'd1;
	localparam logic [3:0] KIND_REDUCE   = 4'd2;
	localparam logic [3:0] KIND_EXEC     = 4'd3;
	localparam logic [3:0] KIND_MASTER   = 4'd4;
	localparam logic [3:0] KIND_MODIFY   = 4'd5;
	localparam logic [3:0] KIND_REMOTE   = 4'd6;
	localparam logic [3:0] KIND_PROTOCOL = 4'd7;
	localparam logic [3:0] KIND_UNKNOWN  = 4'd8;

	localparam logic [7:0] CODE_ADD      = 8'h41;
	localparam logic [7:0] CODE_CONTROL  = 8'h43;
	localparam logic [7:0] CODE_REDUCE   = 8'h44;
	localparam logic [7:0] CODE_EXEC     = 8'h45;
	localparam logic [7:0] CODE_MASTER   = 8'h4C;
	localparam logic [7:0] CODE_MODIFY   = 8'h4D;
	localparam logic [7:0] CODE_REMOTE   = 8'h52;
	localparam logic [7:0] CODE_PROTOCOL = 8'h5A;

	typedef enum logic [3:0] {
		F_NONE,
		F_TIME,
		F_SID,
		F_ORDER,
		F_SECOND,
		F_PRICE,
		F_VOLUME,
		F_SYMBOL,
		F_CURRENCY,
		F_LOT,
		F_TICK,
		F_FLAG
	} field_t;

	typedef struct packed {
		field_t     field;
		logic [2:0] lane;
	} loc_t;

	typedef struct packed {
		logic [7:0] stream_byte;
	} feed_beat_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic [63:0] timestamp;
		logic [15:0] stream_id;
		logic [63:0] order_id;
		logic [63:0] second_id;
		logic [31:0] price;
		logic [31:0] volume;
		logic [63:0] symbol;
		logic [63:0] currency;
		logic [7:0]  lot_size;
		logic [7:0]  tick_size;
		logic [7:0]  flag_char;
	} msg_beat_t;

	function automatic logic [3:0] type_to_kind(input logic [7:0] code);
		logic [3:0] k;
		case (code)
			CODE_ADD:      k = KIND_ADD;
			CODE_CONTROL:  k = KIND_CONTROL;
			CODE_REDUCE:   k = KIND_REDUCE;
			CODE_EXEC:     k = KIND_EXEC;
			CODE_MASTER:   k = KIND_MASTER;
			CODE_MODIFY:   k = KIND_MODIFY;
			CODE_REMOTE:   k = KIND_REMOTE;
			CODE_PROTOCOL: k = KIND_PROTOCOL;
			default:       k = KIND_UNKNOWN;
		endcase
		return k;
	endfunction

	function automatic logic [5:0] payload_len(input logic [3:0] kind);
		logic [5:0] n;
		case (kind)
			KIND_ADD:      n = 6'd27;
			KIND_CONTROL:  n = 6'd11;
			KIND_REDUCE:   n = 6'd22;
			KIND_EXEC:     n = 6'd30;
			KIND_MASTER:   n = 6'd29;
			KIND_MODIFY:   n = 6'd34;
			KIND_REMOTE:   n = 6'd18;
			KIND_PROTOCOL: n = 6'd12;
			default:       n = 6'd1;
		endcase
		return n;
	endfunction

endpackage

### hw/rtl/fmd_chan_if.sv
interface fmd_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/fmd_locate.sv
module fmd_locate (
	input  logic [3:0]    kind,
	input  logic [5:0]    pos,
	output fmd_pkg::loc_t loc
);
	fmd_pkg::field_t field;
	logic [5:0]      start;
	logic [5:0]      offs;

	always_comb begin
		field = fmd_pkg::F_NONE;
		start = 6'd0;
		if (pos < 6'd8) begin
			field = fmd_pkg::F_TIME;
			start = 6'd0;
		end else if (kind == fmd_pkg::KIND_PROTOCOL) begin
			field = fmd_pkg::F_SECOND;
			start = 6'd8;
		end else if (pos < 6'd10) begin
			field = fmd_pkg::F_SID;
			start = 6'd8;
		end else begin
			case (kind)
				fmd_pkg::KIND_ADD: begin
					if (pos < 6'd18) begin
						field = fmd_pkg::F_ORDER;
						start = 6'd10;
					end else if (pos < 6'd22) begin
						field = fmd_pkg::F_PRICE;
						start = 6'd18;
					end else if (pos < 6'd26) begin
						field = fmd_pkg::F_VOLUME;
						start = 6'd22;
					end else begin
						field = fmd_pkg::F_FLAG;
						start = 6'd26;
					end
				end
				fmd_pkg::KIND_CONTROL: begin
					field = fmd_pkg::F_FLAG;
					start = 6'd10;
				end
				fmd_pkg::KIND_REDUCE: begin
					if (pos < 6'd18) begin
						field = fmd_pkg::F_ORDER;
						start = 6'd10;
					end else begin
						field = fmd_pkg::F_VOLUME;
						start = 6'd18;
					end
				end
				fmd_pkg::KIND_EXEC: begin
					if (pos < 6'd18) begin
						field = fmd_pkg::F_ORDER;
						start = 6'd10;
					end else if (pos < 6'd22) begin
						field = fmd_pkg::F_VOLUME;
						start = 6'd18;
					end else begin
						field = fmd_pkg::F_SECOND;
						start = 6'd22;
					end
				end
				fmd_pkg::KIND_MASTER: begin
					if (pos < 6'd18) begin
						field = fmd_pkg::F_SYMBOL;
						start = 6'd10;
					end else if (pos < 6'd26) begin
						field = fmd_pkg::F_CURRENCY;
						start = 6'd18;
					end else if (pos == 6'd26) begin
						field = fmd_pkg::F_LOT;
						start = 6'd26;
					end else if (pos == 6'd27) begin
						field = fmd_pkg::F_TICK;
						start = 6'd27;
					end else begin
						field = fmd_pkg::F_FLAG;
						start = 6'd28;
					end
				end
				fmd_pkg::KIND_MODIFY: begin
					if (pos < 6'd18) begin
						field = fmd_pkg::F_ORDER;
						start = 6'd10;
					end else if (pos < 6'd26) begin
						field = fmd_pkg::F_SECOND;
						start = 6'd18;
					end else if (pos < 6'd30) begin
						field = fmd_pkg::F_PRICE;
						start = 6'd26;
					end else begin
						field = fmd_pkg::F_VOLUME;
						start = 6'd30;
					end
				end
				fmd_pkg::KIND_REMOTE: begin
					field = fmd_pkg::F_ORDER;
					start = 6'd10;
				end
				default: begin
					field = fmd_pkg::F_NONE;
					start = 6'd0;
				end
			endcase
		end
	end

	assign offs      = pos - start;
	assign loc.field = field;
	assign loc.lane  = offs[2:0];
endmodule

### hw/rtl/fmd_core.sv
module fmd_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  logic [7:0]         stream_byte,
	output logic               res_valid,
	output fmd_pkg::msg_beat_t res
);
	logic        in_msg_q, in_msg_d;
	logic [2:0]  kind_q, kind_d;
	logic [5:0]  idx_q, idx_d;
	logic [63:0] time_q, time_d;
	logic [15:0] sid_q, sid_d;
	logic [63:0] order_q, order_d;
	logic [63:0] second_q, second_d;
	logic [31:0] price_q, price_d;
	logic [31:0] volume_q, volume_d;
	logic [63:0] symbol_q, symbol_d;
	logic [63:0] currency_q, currency_d;
	logic [7:0]  lot_q, lot_d;
	logic [7:0]  tick_q, tick_d;
	logic [7:0]  flag_q, flag_d;

	logic [3:0]    kind_wide;
	logic [3:0]    type_kind;
	logic [5:0]    b64;
	logic [4:0]    b32;
	logic [3:0]    b16;
	fmd_pkg::loc_t loc;

	assign kind_wide = {1'b0, kind_q};
	assign type_kind = fmd_pkg::type_to_kind(stream_byte);
	assign b64       = {loc.lane, 3'b000};
	assign b32       = {loc.lane[1:0], 3'b000};
	assign b16       = {loc.lane[0], 3'b000};

	fmd_locate u_locate (
		.kind (kind_wide),
		.pos  (idx_q),
		.loc  (loc)
	);

	always_comb begin
		in_msg_d   = in_msg_q;
		kind_d     = kind_q;
		idx_d      = idx_q;
		time_d     = time_q;
		sid_d      = sid_q;
		order_d    = order_q;
		second_d   = second_q;
		price_d    = price_q;
		volume_d   = volume_q;
		symbol_d   = symbol_q;
		currency_d = currency_q;
		lot_d      = lot_q;
		tick_d     = tick_q;
		flag_d     = flag_q;
		res_valid  = 1'b0;
		res        = '0;
		if (take) begin
			if (!in_msg_q) begin
				if (type_kind == fmd_pkg::KIND_UNKNOWN) begin
					res_valid     = 1'b1;
					res.kind      = fmd_pkg::KIND_UNKNOWN;
					res.flag_char = stream_byte;
				end else begin
					in_msg_d   = 1'b1;
					kind_d     = type_kind[2:0];
					idx_d      = 6'd0;
					time_d     = '0;
					sid_d      = '0;
					order_d    = '0;
					second_d   = '0;
					price_d    = '0;
					volume_d   = '0;
					symbol_d   = '0;
					currency_d = '0;
					lot_d      = '0;
					tick_d     = '0;
					flag_d     = '0;
				end
			end else begin
				case (loc.field)
					fmd_pkg::F_TIME:     time_d[b64 +: 8] = stream_byte;
					fmd_pkg::F_SID:      sid_d[b16 +: 8] = stream_byte;
					fmd_pkg::F_ORDER:    order_d[b64 +: 8] = stream_byte;
					fmd_pkg::F_SECOND:   second_d[b64 +: 8] = stream_byte;
					fmd_pkg::F_PRICE:    price_d[b32 +: 8] = stream_byte;
					fmd_pkg::F_VOLUME:   volume_d[b32 +: 8] = stream_byte;
					fmd_pkg::F_SYMBOL:   symbol_d[b64 +: 8] = stream_byte;
					fmd_pkg::F_CURRENCY: currency_d[b64 +: 8] = stream_byte;
					fmd_pkg::F_LOT:      lot_d = stream_byte;
					fmd_pkg::F_TICK:     tick_d = stream_byte;
					fmd_pkg::F_FLAG:     flag_d = stream_byte;
					default:             flag_d = flag_q;
				endcase
				idx_d = idx_q + 6'd1;
				if (idx_d == fmd_pkg::payload_len(kind_wide)) begin
					res_valid     = 1'b1;
					res.kind      = kind_wide;
					res.timestamp = time_d;
					res.stream_id = sid_d;
					res.order_id  = order_d;
					res.second_id = second_d;
					res.price     = price_d;
					res.volume    = volume_d;
					res.symbol    = symbol_d;
					res.currency  = currency_d;
					res.lot_size  = lot_d;
					res.tick_size = tick_d;
					res.flag_char = flag_d;
					in_msg_d      = 1'b0;
					idx_d         = 6'd0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_msg_q   <= 1'b0;
			kind_q     <= '0;
			idx_q      <= '0;
			time_q     <= '0;
			sid_q      <= '0;
			order_q    <= '0;
			second_q   <= '0;
			price_q    <= '0;
			volume_q   <= '0;
			symbol_q   <= '0;
			currency_q <= '0;
			lot_q      <= '0;
			tick_q     <= '0;
			flag_q     <= '0;
		end else begin
			in_msg_q   <= in_msg_d;
			kind_q     <= kind_d;
			idx_q      <= idx_d;
			time_q     <= time_d;
			sid_q      <= sid_d;
			order_q    <= order_d;
			second_q   <= second_d;
			price_q    <= price_d;
			volume_q   <= volume_d;
			symbol_q   <= symbol_d;
			currency_q <= currency_d;
			lot_q      <= lot_d;
			tick_q     <= tick_d;
			flag_q     <= flag_d;
		end
	end
endmodule

### hw/rtl/feed_message_deframer.sv
// Takes one feed byte per beat and emits one message beat when the last payload byte of a
// message arrives, or at once for a byte that is not a known type code. The block takes one
// byte per clock while input ready is high; the accumulators update on the accepted byte and
// the finished message leaves through an output register backed by a one-entry skid register,
// so bytes keep flowing while one message waits in the output register. Input ready drops
// only while the skid register is occupied.
module feed_message_deframer (
	input logic       clk,
	input logic       arst_n,
	fmd_chan_if.sink   feed,
	fmd_chan_if.source msg
);
	logic               take;
	logic               res_valid;
	fmd_pkg::msg_beat_t res;
	logic               out_valid_q;
	fmd_pkg::msg_beat_t out_q;
	logic               skid_valid_q;
	fmd_pkg::msg_beat_t skid_q;

	assign feed.ready  = !skid_valid_q;
	assign take        = feed.valid && !skid_valid_q;
	assign msg.valid   = out_valid_q;
	assign msg.payload = out_q;

	fmd_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.stream_byte (feed.payload.stream_byte),
		.res_valid   (res_valid),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || msg.ready) begin
				if (skid_valid_q) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= res_valid;
				end
			end else if (res_valid) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || msg.ready) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (res_valid) begin
				out_q <= res;
			end
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register holds a message while the output register is empty");

	a_no_result_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !skid_valid_q)
		else $error("message produced while the skid register is occupied");

	a_unknown_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(msg.valid && msg.payload.kind == fmd_pkg::KIND_UNKNOWN) |->
		(msg.payload.timestamp == '0 && msg.payload.stream_id == '0 &&
		 msg.payload.order_id == '0 && msg.payload.symbol == '0))
		else $error("unknown-type message carries nonzero fields");
endmodule
